// ===== hdl/pmfd_pkg.sv =====
// Shared types and codes for the paged monochrome frame buffer.
// Request and response payload structs, opcodes and the memory command.
// No dependencies.
package pmfd_pkg;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_FILL   = 2'd1;
   localparam logic [1:0] OP_REDRAW = 2'd2;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_NONE = 1'b1;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] x_low;
      logic [5:0] y_low;
      logic [6:0] x_high;
      logic [5:0] y_high;
      logic       pixel_on;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  page_number;
      logic [3:0]  chunk_index;
      logic [63:0] column_bytes;
      logic        last;
   } rsp_type;

   // One word operation handed to the store: read-modify-write and/or emit.
   typedef struct packed {
      logic        write;
      logic        emit;
      logic        pixel_on;
      logic [63:0] mask;
      logic        kind;
      logic [2:0]  page_number;
      logic [3:0]  chunk_index;
      logic        last;
   } cmd_type;

endpackage

// ===== hdl/pmfd_store.sv =====
// Pixel word memory with a registered read and a read-modify-write stage.
// Depends on pmfd_pkg for the command and response types.
module pmfd_store #(
   parameter int WORDS = 128,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             iss_valid,
   input  logic [AW-1:0]    iss_addr,
   input  pmfd_pkg::cmd_type iss_cmd,
   output logic             push_valid,
   output pmfd_pkg::rsp_type push_data
);
   import pmfd_pkg::*;

   logic [63:0] mem [WORDS];

   logic [63:0]   rd_ff;
   logic          s1_valid_ff, s1_valid_in;
   logic [AW-1:0] s1_addr_ff;
   cmd_type       s1_cmd_ff;
   logic          wr_valid_ff, wr_valid_in;
   logic [AW-1:0] wr_addr_ff;
   logic [63:0]   wr_data_ff, wr_data_in;
   logic [63:0]   base;

   // Forward the word written at the edge this read was taken.
   assign base = (wr_valid_ff && (wr_addr_ff == s1_addr_ff)) ? wr_data_ff : rd_ff;

   assign wr_data_in = s1_cmd_ff.pixel_on ? (base | s1_cmd_ff.mask)
                                          : (base & ~s1_cmd_ff.mask);
   assign wr_valid_in = s1_valid_ff && s1_cmd_ff.write;
   assign s1_valid_in = iss_valid;

   assign push_valid             = s1_valid_ff && s1_cmd_ff.emit;
   assign push_data.kind         = s1_cmd_ff.kind;
   assign push_data.page_number  = s1_cmd_ff.page_number;
   assign push_data.chunk_index  = s1_cmd_ff.chunk_index;
   assign push_data.column_bytes = (s1_cmd_ff.kind == KIND_NONE) ? 64'd0 : base;
   assign push_data.last         = s1_cmd_ff.last;

   always_ff @(posedge clock) begin
      if (iss_valid) begin
         rd_ff <= mem[iss_addr];
      end
      if (wr_valid_in) begin
         mem[s1_addr_ff] <= wr_data_in;
      end
      s1_addr_ff <= iss_addr;
      s1_cmd_ff  <= iss_cmd;
      wr_addr_ff <= s1_addr_ff;
      wr_data_ff <= wr_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wr_valid_ff <= wr_valid_in;
      end
   end

endmodule

// ===== hdl/pmfd_rsp_queue.sv =====
// Two-entry response queue between the store and the response channel.
// Depends on pmfd_pkg for the response type.
module pmfd_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  pmfd_pkg::rsp_type push_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pmfd_pkg::rsp_type rsp_data,
   output logic [1:0]        count
);
   import pmfd_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = rsp_valid && rsp_ready;

   assign wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + 2'(push_valid) - 2'(pop);

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/paged_mono_framebuffer_dirty_pages.sv =====
// Top level of the paged monochrome frame buffer with per-page dirty flags.
// Holds the request sequencer and dirty flags; uses pmfd_store, pmfd_rsp_queue
// and pmfd_pkg.
//
// Usage:
//   Requests (req_valid/req_ready, req_data) carry one opcode each. A set
//   pixel request is taken every cycle. A fill request walks every 8-byte
//   word that the clipped rectangle touches, one word per cycle, and the
//   request channel stays closed until the walk ends. A redraw request
//   streams the lowest dirty page as ceil(COLUMNS/8) responses of eight
//   column bytes, one per cycle while rsp_ready is high, or one "none"
//   response when no page is dirty; the first response passes the state
//   register, the store's read stage and a queue slot. Opcode 3 is taken
//   and dropped. The pixel memory is one word per eight columns of a page,
//   with a single registered read port; every write is a read, merge,
//   write back, with the last written word forwarded to the next read.
//   After reset the block sweeps the memory to zero, one word per cycle
//   (PAGES*ceil(COLUMNS/8) words, 128 at the defaults), with req_ready
//   low; all pages come out of reset dirty. When the receiver stalls, up to
//   two responses wait in a small queue and the redraw walk holds.
module paged_mono_framebuffer_dirty_pages #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pmfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pmfd_pkg::rsp_type rsp_data
);
   import pmfd_pkg::*;

   localparam int ROWS   = PAGES * 8;
   localparam int CHUNKS = (COLUMNS + 7) / 8;
   localparam int WORDS  = PAGES * CHUNKS;
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_FILL  = 2'd2;
   localparam logic [1:0] ST_DRAW  = 2'd3;

   // Control state
   logic [1:0]       state_ff, state_in;
   logic [PAGES-1:0] dirty_ff, dirty_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;

   // Walk cursors and rectangle bounds
   logic [PW-1:0] page_ff, page_in;
   logic [PW-1:0] page_end_ff, page_end_in;
   logic [CW-1:0] chunk_ff, chunk_in;
   logic [CW-1:0] chunk_lo_ff, chunk_lo_in;
   logic [CW-1:0] chunk_hi_ff, chunk_hi_in;
   logic [6:0]    xl_ff, xl_in, xh_ff, xh_in;
   logic [5:0]    yl_ff, yl_in, yh_ff, yh_in;
   logic          on_ff, on_in;
   logic          none_ff, none_in;

   logic          req_accept;
   logic          px_in_range;
   logic [6:0]    xh_clip;
   logic [5:0]    yh_clip;
   logic          fill_ok;
   logic          found;
   logic [PW-1:0] low_page;
   logic [7:0]    row_sel;
   logic [7:0]    col_sel;
   logic [63:0]   fill_mask;
   logic [PW-1:0] addr_pg;
   logic [CW-1:0] addr_ck;
   logic [AW-1:0] word_addr;
   logic          credit;
   logic [2:0]    occ_next;

   logic          iss_valid;
   logic [AW-1:0] iss_addr;
   cmd_type       iss_cmd;

   logic          push_valid;
   rsp_type       push_data;
   logic [1:0]    q_count;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // Range check and clipping of request coordinates
   assign px_in_range = (9'(req_data.x_low) < 9'(COLUMNS)) &&
                        (8'(req_data.y_low) < 8'(ROWS));
   assign xh_clip = (9'(req_data.x_high) >= 9'(COLUMNS)) ? 7'(COLUMNS - 1)
                                                         : req_data.x_high;
   assign yh_clip = (8'(req_data.y_high) >= 8'(ROWS)) ? 6'(ROWS - 1)
                                                      : req_data.y_high;
   assign fill_ok = (req_data.x_low <= xh_clip) && (req_data.y_low <= yh_clip);

   // Lowest dirty page
   always_comb begin
      found    = 1'b0;
      low_page = '0;
      for (int p = PAGES - 1; p >= 0; p--) begin
         if (dirty_ff[p]) begin
            found    = 1'b1;
            low_page = PW'(p);
         end
      end
   end

   // Byte mask of the current fill word: column and row windows
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         col_sel[b] = (9'({chunk_ff, 3'(b)}) >= 9'(xl_ff)) &&
                      (9'({chunk_ff, 3'(b)}) <= 9'(xh_ff));
         row_sel[b] = (8'({page_ff, 3'(b)}) >= 8'(yl_ff)) &&
                      (8'({page_ff, 3'(b)}) <= 8'(yh_ff));
      end
      for (int b = 0; b < 8; b++) begin
         fill_mask[b*8 +: 8] = col_sel[b] ? row_sel : 8'd0;
      end
   end

   // Word address: page * CHUNKS + chunk
   assign addr_pg   = (state_ff == ST_IDLE) ? PW'(req_data.y_low[5:3]) : page_ff;
   assign addr_ck   = (state_ff == ST_IDLE) ? CW'(req_data.x_low[6:3]) : chunk_ff;
   assign word_addr = AW'(AW'(addr_pg) * AW'(CHUNKS)) + AW'(addr_ck);
   assign iss_addr  = (state_ff == ST_CLEAR) ? clr_addr_ff : word_addr;

   // Room for one more response once the queue and the read in flight settle
   assign occ_next = 3'(q_count) + 3'(push_valid) - 3'(rsp_valid && rsp_ready);
   assign credit   = (occ_next < 3'd2);

   always_comb begin
      state_in    = state_ff;
      dirty_in    = dirty_ff;
      clr_addr_in = clr_addr_ff;
      page_in     = page_ff;
      page_end_in = page_end_ff;
      chunk_in    = chunk_ff;
      chunk_lo_in = chunk_lo_ff;
      chunk_hi_in = chunk_hi_ff;
      xl_in       = xl_ff;
      xh_in       = xh_ff;
      yl_in       = yl_ff;
      yh_in       = yh_ff;
      on_in       = on_ff;
      none_in     = none_ff;
      iss_valid   = 1'b0;
      iss_cmd     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one word per cycle
            iss_valid        = 1'b1;
            iss_cmd.write    = 1'b1;
            iss_cmd.mask     = '1;
            iss_cmd.pixel_on = 1'b0;
            if (clr_addr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.opcode)
                  OP_SET: begin
                     if (px_in_range) begin
                        iss_valid        = 1'b1;
                        iss_cmd.write    = 1'b1;
                        iss_cmd.pixel_on = req_data.pixel_on;
                        iss_cmd.mask     = 64'd1 << {req_data.x_low[2:0],
                                                     req_data.y_low[2:0]};
                        dirty_in[addr_pg] = 1'b1;
                     end
                  end
                  OP_FILL: begin
                     if (fill_ok) begin
                        state_in    = ST_FILL;
                        page_in     = PW'(req_data.y_low[5:3]);
                        page_end_in = PW'(yh_clip[5:3]);
                        chunk_in    = CW'(req_data.x_low[6:3]);
                        chunk_lo_in = CW'(req_data.x_low[6:3]);
                        chunk_hi_in = CW'(xh_clip[6:3]);
                        xl_in       = req_data.x_low;
                        xh_in       = xh_clip;
                        yl_in       = req_data.y_low;
                        yh_in       = yh_clip;
                        on_in       = req_data.pixel_on;
                     end
                  end
                  OP_REDRAW: begin
                     // Pick the page now and mark it clean
                     state_in = ST_DRAW;
                     none_in  = !found;
                     page_in  = low_page;
                     chunk_in = '0;
                     if (found) begin
                        dirty_in[low_page] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            iss_valid         = 1'b1;
            iss_cmd.write     = 1'b1;
            iss_cmd.pixel_on  = on_ff;
            iss_cmd.mask      = fill_mask;
            dirty_in[page_ff] = 1'b1;
            if (chunk_ff == chunk_hi_ff) begin
               chunk_in = chunk_lo_ff;
               if (page_ff == page_end_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  page_in = page_ff + 1'b1;
               end
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         ST_DRAW: begin
            // Advance only when the response queue has room
            if (credit) begin
               iss_valid    = 1'b1;
               iss_cmd.emit = 1'b1;
               if (none_ff) begin
                  iss_cmd.kind = KIND_NONE;
                  iss_cmd.last = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  iss_cmd.kind        = KIND_DATA;
                  iss_cmd.page_number = 3'(page_ff);
                  iss_cmd.chunk_index = 4'(chunk_ff);
                  iss_cmd.last        = (chunk_ff == CW'(CHUNKS - 1));
                  if (chunk_ff == CW'(CHUNKS - 1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     chunk_in = chunk_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         dirty_ff    <= '1;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         dirty_ff    <= dirty_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      page_end_ff <= page_end_in;
      chunk_ff    <= chunk_in;
      chunk_lo_ff <= chunk_lo_in;
      chunk_hi_ff <= chunk_hi_in;
      xl_ff       <= xl_in;
      xh_ff       <= xh_in;
      yl_ff       <= yl_in;
      yh_ff       <= yh_in;
      on_ff       <= on_in;
      none_ff     <= none_in;
   end

   pmfd_store #(
      .WORDS(WORDS),
      .AW   (AW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .iss_valid (iss_valid),
      .iss_addr  (iss_addr),
      .iss_cmd   (iss_cmd),
      .push_valid(push_valid),
      .push_data (push_data)
   );

   pmfd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .count     (q_count)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for paged_mono_framebuffer_dirty_pages: directed table, then random
// set/fill/redraw/unused traffic, checked against a frame-and-dirty-flag predictor,
// with typed expectations for some directed rows. Depends on pmfd_pkg and the RTL under hdl/.
module testbench;
   import pmfd_pkg::*;

   localparam int COLUMNS = 128;
   localparam int PAGES   = 8;
   localparam int ROWS    = PAGES * 8;
   localparam int CHUNKS  = (COLUMNS + 7) / 8;

   // The fourth opcode is taken and dropped by the block.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Worst case is roughly 250 requests x (a full-screen fill or 16 stalled chunks);
   // this is several times that, plus the clearing sweep after reset.
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          HOLD_CYCLES  = 80;
   localparam int          RANDOM_COUNT = 220;
   localparam int          PRINT_CAP    = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   paged_mono_framebuffer_dirty_pages #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow frame: one byte per column per page, plus a dirty bit per page.
   // ------------------------------------------------------------------
   logic [7:0]       frame_bytes [PAGES][COLUMNS];
   logic [PAGES-1:0] dirty_pages;
   rsp_type          pending_chunks [$];

   int unsigned cycle_count   = 0;
   int          error_count   = 0;
   int          sent_sets     = 0;
   int          sent_fills    = 0;
   int          sent_redraws  = 0;
   int          sent_unused   = 0;
   int          data_chunks   = 0;
   int          none_results  = 0;
   int          stalled_edges = 0;

   // Handshake knobs shared between the sender and the receiver.
   bit steady         = 1'b0;   // both sides stop idling while set
   bit hold_off_armed = 1'b0;   // sender asks the receiver for a long stall
   int hold_left      = 0;

   task automatic paint_pixel(input int x, input int y, input bit on);
      int page;
      page = y / 8;
      if (x >= COLUMNS || y >= ROWS) return;
      dirty_pages[page] = 1'b1;
      frame_bytes[page][x][y % 8] = on;
   endtask

   // Advance the shadow frame by one request; queue the chunks a redraw sends
   // unless the caller supplies its own typed expectation.
   task automatic apply_request(input req_type r, input bit predicted);
      int      x, y, page, col, c, b, xh, yh;
      rsp_type chunk;
      case (r.opcode)
         OP_SET: begin
            paint_pixel(r.x_low, r.y_low, r.pixel_on);
         end
         OP_FILL: begin
            xh = (r.x_high >= COLUMNS) ? COLUMNS - 1 : r.x_high;
            yh = (r.y_high >= ROWS) ? ROWS - 1 : r.y_high;
            // Empty rectangle: nothing written, nothing dirtied.
            if (r.x_low <= r.x_high && r.y_low <= r.y_high) begin
               for (x = r.x_low; x <= xh; x++)
                  for (y = r.y_low; y <= yh; y++)
                     paint_pixel(x, y, r.pixel_on);
            end
         end
         OP_REDRAW: begin
            page = PAGES;
            for (int p = PAGES - 1; p >= 0; p--)
               if (dirty_pages[p]) page = p;
            if (page == PAGES) begin
               // No dirty page: one lone marker result.
               chunk = '{KIND_NONE, 3'd0, 4'd0, 64'd0, 1'b1};
               if (predicted) pending_chunks.push_back(chunk);
            end else begin
               for (c = 0; c < CHUNKS; c++) begin
                  chunk.kind         = KIND_DATA;
                  chunk.page_number  = page[2:0];
                  chunk.chunk_index  = c[3:0];
                  chunk.column_bytes = '0;
                  for (b = 0; b < 8; b++) begin
                     col = c * 8 + b;
                     if (col < COLUMNS) chunk.column_bytes[8*b +: 8] = frame_bytes[page][col];
                  end
                  chunk.last = (c == CHUNKS - 1);
                  if (predicted) pending_chunks.push_back(chunk);
               end
               dirty_pages[page] = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Mismatch reporting and response checking.
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_chunk(input rsp_type got);
      rsp_type want;
      if (pending_chunks.size() == 0) begin
         report_mismatch($sformatf("response with nothing pending: %p", got));
         return;
      end
      want = pending_chunks.pop_front();
      if (got.kind !== want.kind)
         report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.page_number !== want.page_number)
         report_mismatch($sformatf("page_number %0d, want %0d",
                                   got.page_number, want.page_number));
      if (got.chunk_index !== want.chunk_index)
         report_mismatch($sformatf("chunk_index %0d, want %0d",
                                   got.chunk_index, want.chunk_index));
      if (got.column_bytes !== want.column_bytes)
         report_mismatch($sformatf("column_bytes %h, want %h (page %0d chunk %0d)",
                                   got.column_bytes, want.column_bytes,
                                   want.page_number, want.chunk_index));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
   endtask

   // Sample the response channel at the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_data.kind == KIND_NONE) none_results++;
         else data_chunks++;
         check_chunk(rsp_data);
      end
      if (!reset && !req_ready && req_valid) stalled_edges++;
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d chunks still pending",
                  cycle_count, pending_chunks.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: drive rsp_ready at the falling edge. Idle about 28% of the time,
   // never while steady is set, and hold off for a long stretch when armed.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_armed) begin
         rsp_ready      <= 1'b0;
         hold_left      <= HOLD_CYCLES - 1;
         hold_off_armed <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 28);
      end
   end

   // ------------------------------------------------------------------
   // Sender side. Called at a falling edge; returns at the falling edge
   // after the request is accepted.
   // ------------------------------------------------------------------
   task automatic send_request(input req_type r, input bit predicted);
      // Drop valid for an idle cycle now and then before offering the request.
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(r, predicted);
      case (r.opcode)
         OP_SET:    sent_sets++;
         OP_FILL:   sent_fills++;
         OP_REDRAW: sent_redraws++;
         default:   sent_unused++;
      endcase
      @(negedge clock);
   endtask

   // Lower valid and hold until every expected chunk has drained.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_chunks.size() != 0);
   endtask

   typedef struct {
      req_type     request;
      bit          typed;
      logic        kind;
      logic [2:0]  page;
      logic [63:0] bytes;
   } directed_row;

   directed_row directed_rows [$];

   task automatic add_row(input logic [1:0] op, input int xl, input int yl,
                          input int xh, input int yh, input bit on,
                          input bit typed = 1'b0, input logic kind = KIND_DATA,
                          input int page = 0, input logic [63:0] bytes = '0);
      directed_row row;
      row.request = '{op, xl[6:0], yl[5:0], xh[6:0], yh[5:0], on};
      row.typed   = typed;
      row.kind    = kind;
      row.page    = page[2:0];
      row.bytes   = bytes;
      directed_rows.push_back(row);
   endtask

   // Queue a typed expectation: either the lone marker or a page whose every
   // chunk holds the same eight bytes.
   task automatic push_typed(input directed_row row);
      rsp_type chunk;
      if (row.kind == KIND_NONE) begin
         chunk = '{KIND_NONE, 3'd0, 4'd0, 64'd0, 1'b1};
         pending_chunks.push_back(chunk);
      end else begin
         for (int c = 0; c < CHUNKS; c++) begin
            chunk = '{KIND_DATA, row.page, c[3:0], row.bytes, (c == CHUNKS - 1)};
            pending_chunks.push_back(chunk);
         end
      end
   endtask

   // Build a random request; all fields start random so that every bit toggles,
   // then the opcode and any bounds that matter are shaped.
   function automatic req_type random_request();
      req_type r;
      int      roll, shape, span;
      r     = req_type'($urandom);
      roll  = $urandom_range(0, 99);
      shape = $urandom_range(0, 99);
      if (roll < 42) begin
         r.opcode = OP_SET;
      end else if (roll < 66) begin
         r.opcode = OP_FILL;
         if (shape < 60) begin
            // Small rectangle: a few words of work at most.
            span = $urandom_range(0, 12);
            r.x_high = (r.x_low + span > COLUMNS - 1) ? 7'(COLUMNS - 1) : 7'(r.x_low + span);
            span = $urandom_range(0, 10);
            r.y_high = (r.y_low + span > ROWS - 1) ? 6'(ROWS - 1) : 6'(r.y_low + span);
         end else if (shape < 80) begin
            // Empty rectangle: left edge past the right edge.
            r.x_low  = 7'($urandom_range(1, COLUMNS - 1));
            r.x_high = 7'($urandom_range(0, r.x_low - 1));
         end else if (shape >= 95) begin
            r.x_low  = '0;
            r.y_low  = '0;
            r.x_high = 7'(COLUMNS - 1);
            r.y_high = 6'(ROWS - 1);
         end
      end else if (roll < 95) begin
         r.opcode = OP_REDRAW;
      end else begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      req_type r;
      int      sent;

      for (int p = 0; p < PAGES; p++)
         for (int x = 0; x < COLUMNS; x++)
            frame_bytes[p][x] = 8'h00;
      dirty_pages = '1;

      // Out of reset every page is dirty and blank: eight blank pages, then
      // the marker.
      for (int p = 0; p < PAGES; p++)
         add_row(OP_REDRAW, 0, 0, 0, 0, 0, 1'b1, KIND_DATA, p, 64'h0);
      add_row(OP_REDRAW, 127, 63, 127, 63, 1, 1'b1, KIND_NONE);
      // Corner pixels, then send the two pages they dirtied.
      add_row(OP_SET, 0, 0, 0, 0, 1);
      add_row(OP_SET, 127, 63, 0, 0, 1);
      add_row(OP_REDRAW, 0, 0, 0, 0, 0);
      add_row(OP_REDRAW, 0, 0, 0, 0, 0);
      // Whole screen on; page 0 comes back all ones.
      add_row(OP_FILL, 0, 0, 127, 63, 1);
      add_row(OP_REDRAW, 0, 0, 0, 0, 0, 1'b1, KIND_DATA, 0, 64'hFFFF_FFFF_FFFF_FFFF);
      // Empty rectangles on either axis.
      add_row(OP_FILL, 10, 0, 5, 63, 0);
      add_row(OP_FILL, 0, 40, 127, 39, 0);
      // Clear a small block and one pixel, drop an unused opcode.
      add_row(OP_FILL, 3, 5, 9, 20, 0);
      add_row(OP_SET, 64, 33, 0, 0, 0);
      add_row(OP_UNUSED, 127, 63, 127, 63, 1);
      add_row(OP_REDRAW, 0, 0, 0, 0, 0);
      add_row(OP_REDRAW, 0, 0, 0, 0, 0);
      add_row(OP_REDRAW, 0, 0, 0, 0, 0);

      // Hold reset, then release it at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].request, !directed_rows[i].typed);
         if (directed_rows[i].typed) push_typed(directed_rows[i]);
      end

      sent = 0;
      while (sent < RANDOM_COUNT) begin
         if (sent == 30) begin
            // Long receiver stall while redraws keep coming: back the block up.
            hold_off_armed <= 1'b1;
            for (int k = 0; k <= PAGES; k++) begin
               r = random_request();
               r.opcode = OP_REDRAW;
               send_request(r, 1'b1);
            end
            sent += PAGES + 1;
         end
         if (sent >= 100 && sent < 150) steady <= 1'b1;
         else steady <= 1'b0;
         if (sent == 170) drain_responses();
         send_request(random_request(), 1'b1);
         sent++;
      end
      req_valid <= 1'b0;

      // Wait for the tail, then give spurious responses a chance to show.
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d set, %0d fill, %0d redraw and %0d unused-opcode requests.",
               sent_sets, sent_fills, sent_redraws, sent_unused);
      $display("Checked %0d page chunks and %0d no-dirty-page results; input stalled %0d edges.",
               data_chunks, none_results, stalled_edges);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
